/* src/fatcd_pkg.sv */
// Shared types and constants for the FAT cluster address and chain decoder.
package fatcd_pkg;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2,
    KIND_EXFAT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_LOCATE = 2'd0,
    CMD_SECTOR = 2'd1,
    CMD_DECODE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SECTOR_BYTES_LOG2   = 3'd0,
    REG_CLUSTER_SECTORS_LOG2 = 3'd1,
    REG_RESERVED_SECTORS    = 3'd2,
    REG_FAT_COPIES          = 3'd3,
    REG_FAT_SIZE_SECTORS    = 3'd4,
    REG_ROOT_ENTRY_COUNT    = 3'd5,
    REG_VOLUME_SECTORS      = 3'd6,
    REG_ROOT_START_CLUSTER  = 3'd7
  } reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [2:0]  SettleCycles = 3'd6;

  localparam logic [3:0]  SblMin = 4'd9;
  localparam logic [3:0]  SblMax = 4'd12;

  localparam logic [31:0] Fat12Limit = 32'd4085;
  localparam logic [31:0] Fat16Limit = 32'd65525;

  localparam logic [11:0] Fat12Mask = 12'h0fff;
  localparam logic [11:0] Fat12End  = 12'h0ff8;
  localparam logic [11:0] Fat12Bad  = 12'h0ff7;
  localparam logic [15:0] Fat16End  = 16'hfff8;
  localparam logic [15:0] Fat16Bad  = 16'hfff7;
  localparam logic [31:0] Fat32Mask = 32'h0fffffff;
  localparam logic [31:0] Fat32End  = 32'h0ffffff8;
  localparam logic [31:0] Fat32Bad  = 32'h0ffffff7;
  localparam logic [31:0] ExfatEnd  = 32'hfffffff8;
  localparam logic [31:0] ExfatBad  = 32'hfffffff7;

  typedef struct packed {
    logic        settled;
    logic [3:0]  sbl;
    logic [11:0] sector_mask;
    logic [2:0]  csl;
    logic [15:0] reserved;
    kind_e       kind;
    logic [40:0] data_full;
    logic [31:0] total;
    logic [31:0] root_start;
  } geom_t;

endpackage

/* src/fat_cluster_address_and_chain_decode.sv */
// Top level of the FAT cluster address and chain decoder.
// An accepted input beat is captured in the input register and its result in the result register.
// Throughput is one beat per cycle while the geometry has settled and the output is not stalled.
// The geometry is derived through a six-stage pipeline from the configuration registers,
// so input is held off after reset and after each configuration write while it settles.
// Reset is asynchronous and active low and restores the documented register defaults.
module fat_cluster_address_and_chain_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fatcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fatcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // cluster_in [31:0], sector_in [63:32], fat_word [95:64]
  input  logic [95:0]                     s_axis_tdata,
  // command
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cluster_first_sector [31:0], fat_entry_sector [63:32], fat_entry_offset [75:64],
  // cluster_out [107:76], chain_end [108], bad_cluster [109], range_error [110],
  // data_start_sector [142:111], root_start_sector [174:143], cluster_total [206:175]
  output logic [207:0]                    m_axis_tdata,
  // fat_kind
  output logic [1:0]                      m_axis_tuser
);

  fatcd_pkg::geom_t geom;

  fatcd_geometry u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  logic        adv;
  logic        s1_valid_q;
  logic [1:0]  cmd_q;
  logic [31:0] cl_q;
  logic [31:0] sec_q;
  logic [31:0] word_q;

  logic [31:0] first_d, fsec_d, cout_d;
  logic [11:0] foff_d;
  logic        end_d, bad_d, rerr_d;

  logic [31:0] first_q, fsec_q, cout_q, data_start_q, root_start_q, total_q;
  logic [11:0] foff_q;
  logic        end_q, bad_q, rerr_q;
  logic [1:0]  kind_q;
  logic        out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = geom.settled && (adv || !s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv || !s1_valid_q) begin
        s1_valid_q <= s_axis_tvalid && s_axis_tready;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q  <= s_axis_tuser;
      cl_q   <= s_axis_tdata[31:0];
      sec_q  <= s_axis_tdata[63:32];
      word_q <= s_axis_tdata[95:64];
    end
  end

  always_comb begin
    logic [33:0] boff;
    logic [33:0] boff_sec;
    logic [40:0] sec_ext;
    logic [40:0] sec_rel;
    logic [40:0] sec_cl;
    logic [31:0] fat12_raw;
    logic [11:0] v12;
    logic [15:0] v16;
    logic [31:0] v32;

    case (geom.kind)
      fatcd_pkg::KIND_FAT12: boff = {2'b0, cl_q} + {3'b0, cl_q[31:1]};
      fatcd_pkg::KIND_FAT16: boff = {1'b0, cl_q, 1'b0};
      default:               boff = {cl_q, 2'b0};
    endcase
    boff_sec  = boff >> geom.sbl;
    sec_ext   = {9'b0, sec_q};
    sec_rel   = sec_ext - geom.data_full;
    sec_cl    = sec_rel >> geom.csl;
    fat12_raw = cl_q[0] ? (word_q >> 4) : word_q;
    v12       = fat12_raw[11:0] & fatcd_pkg::Fat12Mask;
    v16       = word_q[15:0];
    v32       = word_q & fatcd_pkg::Fat32Mask;

    first_d = 32'd0;
    fsec_d  = 32'd0;
    foff_d  = 12'd0;
    cout_d  = 32'd0;
    end_d   = 1'b0;
    bad_d   = 1'b0;
    rerr_d  = 1'b0;

    if (cmd_q == fatcd_pkg::CMD_LOCATE || cmd_q == fatcd_pkg::CMD_DECODE) begin
      first_d = ((cl_q - 32'd2) << geom.csl) + geom.data_full[31:0];
      fsec_d  = {16'b0, geom.reserved} + boff_sec[31:0];
      foff_d  = boff[11:0] & geom.sector_mask;
      rerr_d  = (cl_q < 32'd2);
    end

    case (fatcd_pkg::cmd_e'(cmd_q))
      fatcd_pkg::CMD_SECTOR: begin
        if (sec_ext < geom.data_full) begin
          rerr_d = 1'b1;
        end else begin
          cout_d = sec_cl[31:0] + 32'd2;
        end
      end
      fatcd_pkg::CMD_DECODE: begin
        case (geom.kind)
          fatcd_pkg::KIND_FAT12: begin
            cout_d = {20'b0, v12};
            end_d  = (v12 >= fatcd_pkg::Fat12End);
            bad_d  = (v12 == fatcd_pkg::Fat12Bad);
          end
          fatcd_pkg::KIND_FAT16: begin
            cout_d = {16'b0, v16};
            end_d  = (v16 >= fatcd_pkg::Fat16End);
            bad_d  = (v16 == fatcd_pkg::Fat16Bad);
          end
          fatcd_pkg::KIND_FAT32: begin
            cout_d = v32;
            end_d  = (v32 >= fatcd_pkg::Fat32End);
            bad_d  = (v32 == fatcd_pkg::Fat32Bad);
          end
          default: begin
            cout_d = word_q;
            end_d  = (word_q >= fatcd_pkg::ExfatEnd);
            bad_d  = (word_q == fatcd_pkg::ExfatBad);
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      first_q      <= first_d;
      fsec_q       <= fsec_d;
      foff_q       <= foff_d;
      cout_q       <= cout_d;
      end_q        <= end_d;
      bad_q        <= bad_d;
      rerr_q       <= rerr_d;
      data_start_q <= geom.data_full[31:0];
      root_start_q <= geom.root_start;
      total_q      <= geom.total;
      kind_q       <= geom.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {1'b0, total_q, root_start_q, data_start_q, rerr_q, bad_q, end_q,
                          cout_q, foff_q, fsec_q, first_q};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> geom.settled)
    else $error("Input accepted while the geometry is still settling.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("Input not held off after a configuration write.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[108] && m_axis_tdata[109]))
    else $error("End of chain and bad cluster raised together.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_valid_q))
    else $error("Result beat appeared without an item in the input register.");
`endif

endmodule

/* src/fatcd_geometry.sv */
// Configuration registers and the pipelined derivation of the volume geometry.
module fatcd_geometry (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fatcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fatcd_pkg::CfgDataW-1:0]  cfg_data_i,
  output fatcd_pkg::geom_t                geom_o
);

  logic [3:0]  sbl_cfg_q;
  logic [2:0]  csl_q;
  logic [15:0] reserved_q;
  logic [7:0]  fat_copies_q;
  logic [31:0] fat_size_q;
  logic [15:0] root_entries_q;
  logic [31:0] volume_q;
  logic [27:0] root_cluster_q;

  logic [3:0]  sbl_eff;
  logic [11:0] mask_eff;
  logic [21:0] root_bytes;
  logic [21:0] root_secs_full;

  logic [39:0] prod_q;
  logic [12:0] root_secs_q;
  logic [3:0]  sbl_q;
  logic [11:0] mask_q;
  logic [40:0] fats_end_q;
  logic [12:0] root_secs2_q;
  logic [40:0] data_full_q;
  logic [40:0] fats_end3_q;
  logic [31:0] total_q;
  logic [31:0] data_secs;
  logic [40:0] vol_ext;
  fatcd_pkg::kind_e kind_q;
  logic [31:0] root_first_q;
  logic [31:0] root_start_q;
  logic [31:0] root_rel;
  logic [2:0]  settle_q;
  logic [2:0]  settle_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbl_cfg_q      <= 4'd9;
      csl_q          <= 3'd0;
      reserved_q     <= 16'd1;
      fat_copies_q   <= 8'd2;
      fat_size_q     <= 32'd1;
      root_entries_q <= 16'd512;
      volume_q       <= 32'd0;
      root_cluster_q <= 28'd2;
    end else if (cfg_we_i) begin
      case (fatcd_pkg::reg_e'(cfg_idx_i))
        fatcd_pkg::REG_SECTOR_BYTES_LOG2:    sbl_cfg_q      <= cfg_data_i[3:0];
        fatcd_pkg::REG_CLUSTER_SECTORS_LOG2: csl_q          <= cfg_data_i[2:0];
        fatcd_pkg::REG_RESERVED_SECTORS:     reserved_q     <= cfg_data_i[15:0];
        fatcd_pkg::REG_FAT_COPIES:           fat_copies_q   <= cfg_data_i[7:0];
        fatcd_pkg::REG_FAT_SIZE_SECTORS:     fat_size_q     <= cfg_data_i[31:0];
        fatcd_pkg::REG_ROOT_ENTRY_COUNT:     root_entries_q <= cfg_data_i[15:0];
        fatcd_pkg::REG_VOLUME_SECTORS:       volume_q       <= cfg_data_i[31:0];
        fatcd_pkg::REG_ROOT_START_CLUSTER:   root_cluster_q <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sbl_cfg_q < fatcd_pkg::SblMin) begin
      sbl_eff = fatcd_pkg::SblMin;
    end else if (sbl_cfg_q > fatcd_pkg::SblMax) begin
      sbl_eff = fatcd_pkg::SblMax;
    end else begin
      sbl_eff = sbl_cfg_q;
    end
    mask_eff       = 12'hfff >> (fatcd_pkg::SblMax - sbl_eff);
    root_bytes     = {1'b0, root_entries_q, 5'b0} + {10'b0, mask_eff};
    root_secs_full = root_bytes >> sbl_eff;
  end

  assign vol_ext   = {9'b0, volume_q};
  assign data_secs = (vol_ext > data_full_q) ? 32'(vol_ext - data_full_q) : 32'd0;
  assign root_rel  = {4'b0, root_cluster_q} - 32'd2;

  always_ff @(posedge clk_i) begin
    prod_q       <= {32'b0, fat_copies_q} * {8'b0, fat_size_q};
    root_secs_q  <= root_secs_full[12:0];
    sbl_q        <= sbl_eff;
    mask_q       <= mask_eff;
    fats_end_q   <= {25'b0, reserved_q} + {1'b0, prod_q};
    root_secs2_q <= root_secs_q;
    data_full_q  <= fats_end_q + {28'b0, root_secs2_q};
    fats_end3_q  <= fats_end_q;
    total_q      <= data_secs >> csl_q;
    if (total_q == 32'd0) begin
      kind_q <= fatcd_pkg::KIND_EXFAT;
    end else if (total_q < fatcd_pkg::Fat12Limit) begin
      kind_q <= fatcd_pkg::KIND_FAT12;
    end else if (total_q < fatcd_pkg::Fat16Limit) begin
      kind_q <= fatcd_pkg::KIND_FAT16;
    end else begin
      kind_q <= fatcd_pkg::KIND_FAT32;
    end
    root_first_q <= (root_rel << csl_q) + data_full_q[31:0];
    if (kind_q == fatcd_pkg::KIND_FAT12 || kind_q == fatcd_pkg::KIND_FAT16) begin
      root_start_q <= fats_end3_q[31:0];
    end else begin
      root_start_q <= root_first_q;
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      settle_d = fatcd_pkg::SettleCycles;
    end else if (settle_q != 3'd0) begin
      settle_d = settle_q - 3'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= fatcd_pkg::SettleCycles;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign geom_o.settled     = (settle_q == 3'd0);
  assign geom_o.sbl         = sbl_q;
  assign geom_o.sector_mask = mask_q;
  assign geom_o.csl         = csl_q;
  assign geom_o.reserved    = reserved_q;
  assign geom_o.kind        = kind_q;
  assign geom_o.data_full   = data_full_q;
  assign geom_o.total       = total_q;
  assign geom_o.root_start  = root_start_q;

endmodule

/* tb/fatcd_lookup_checker.sv */
// Checker that predicts and compares every result beat of the FAT cluster address decoder.
module fatcd_lookup_checker
  import fatcd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [95:0]          in_data_i,
  input  logic [1:0]           in_user_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [207:0]         out_data_i,
  input  logic [1:0]           out_user_i,
  output int                   failures_o,
  output int                   pending_o,
  output int                   results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  sbl;
    logic [2:0]  csl;
    logic [15:0] reserved;
    logic [7:0]  copies;
    logic [31:0] fat_size;
    logic [15:0] root_entries;
    logic [31:0] volume;
    logic [27:0] root_cluster;
  } geometry_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] first_sector;
    logic [31:0] entry_sector;
    logic [11:0] entry_offset;
    logic [31:0] next_cluster;
    logic        chain_end;
    logic        bad_cluster;
    logic        range_error;
    logic [31:0] data_start;
    logic [31:0] root_start;
    logic [31:0] total;
  } lookup_t;

  localparam geometry_t GeometryAtReset = '{sbl: 4'd9, csl: 3'd0, reserved: 16'd1,
    copies: 8'd2, fat_size: 32'd1, root_entries: 16'd512, volume: 32'd0,
    root_cluster: 28'd2};

  geometry_t geometry;
  lookup_t   expected_results[$];

  initial begin
    failures_o = 0;
    pending_o  = 0;
    results_o  = 0;
  end

  function automatic logic [31:0] cluster_to_sector(logic [31:0] cluster, logic [2:0] csl,
                                                     logic [31:0] data_start);
    logic [31:0] rel;
    rel = cluster - 32'd2;
    return (rel << csl) + data_start;
  endfunction

  function automatic lookup_t predict_lookup(geometry_t g, logic [1:0] cmd, logic [95:0] item);
    lookup_t     r;
    logic [3:0]  sbl;
    logic [31:0] cl, sec, word;
    logic [63:0] bps, root_secs, fats_end, data_full, data_secs, total, boff, v;
    cl   = item[31:0];
    sec  = item[63:32];
    word = item[95:64];
    sbl  = (g.sbl < SblMin) ? SblMin : ((g.sbl > SblMax) ? SblMax : g.sbl);
    bps  = 64'd1 << sbl;
    root_secs = (64'(g.root_entries) * 64'd32 + bps - 64'd1) >> sbl;
    fats_end  = 64'(g.reserved) + 64'(g.copies) * 64'(g.fat_size);
    data_full = fats_end + root_secs;
    data_secs = (64'(g.volume) > data_full) ? 64'(g.volume) - data_full : 64'd0;
    total     = data_secs >> g.csl;
    r = '0;
    r.data_start = data_full[31:0];
    r.total      = total[31:0];
    if (total == 64'd0) begin
      r.kind = KIND_EXFAT;
    end else if (total < 64'(Fat12Limit)) begin
      r.kind = KIND_FAT12;
    end else if (total < 64'(Fat16Limit)) begin
      r.kind = KIND_FAT16;
    end else begin
      r.kind = KIND_FAT32;
    end
    if (r.kind == KIND_FAT12 || r.kind == KIND_FAT16) begin
      r.root_start = fats_end[31:0];
    end else begin
      r.root_start = cluster_to_sector({4'd0, g.root_cluster}, g.csl, r.data_start);
    end
    if (cmd == CMD_LOCATE || cmd == CMD_DECODE) begin
      if (r.kind == KIND_FAT12) begin
        boff = 64'(cl) + 64'(cl >> 1);
      end else if (r.kind == KIND_FAT16) begin
        boff = 64'(cl) << 1;
      end else begin
        boff = 64'(cl) << 2;
      end
      r.first_sector = cluster_to_sector(cl, g.csl, r.data_start);
      r.entry_sector = 32'(64'(g.reserved) + (boff >> sbl));
      r.entry_offset = 12'(boff & (bps - 64'd1));
      r.range_error  = (cl < 32'd2);
    end
    if (cmd == CMD_SECTOR) begin
      if (64'(sec) < data_full) begin
        r.range_error = 1'b1;
      end else begin
        r.next_cluster = 32'(((64'(sec) - data_full) >> g.csl) + 64'd2);
      end
    end else if (cmd == CMD_DECODE) begin
      case (r.kind)
        KIND_FAT12: begin
          v = 64'(cl[0] ? (word >> 4) : word) & 64'(Fat12Mask);
          r.chain_end   = (v >= 64'(Fat12End));
          r.bad_cluster = (v == 64'(Fat12Bad));
        end
        KIND_FAT16: begin
          v = 64'(word[15:0]);
          r.chain_end   = (v >= 64'(Fat16End));
          r.bad_cluster = (v == 64'(Fat16Bad));
        end
        KIND_FAT32: begin
          v = 64'(word) & 64'(Fat32Mask);
          r.chain_end   = (v >= 64'(Fat32End));
          r.bad_cluster = (v == 64'(Fat32Bad));
        end
        default: begin
          v = 64'(word);
          r.chain_end   = (v >= 64'(ExfatEnd));
          r.bad_cluster = (v == 64'(ExfatBad));
        end
      endcase
      r.next_cluster = v[31:0];
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      failures_o++;
      if (failures_o <= 10) begin
        $display("mismatch in %s on result beat %0d: expected %h, got %h",
                 name, results_o, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_t got, want;
    if (!rst_ni) begin
      geometry = GeometryAtReset;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SECTOR_BYTES_LOG2:    geometry.sbl          = cfg_data_i[3:0];
          REG_CLUSTER_SECTORS_LOG2: geometry.csl          = cfg_data_i[2:0];
          REG_RESERVED_SECTORS:     geometry.reserved     = cfg_data_i[15:0];
          REG_FAT_COPIES:           geometry.copies       = cfg_data_i[7:0];
          REG_FAT_SIZE_SECTORS:     geometry.fat_size     = cfg_data_i;
          REG_ROOT_ENTRY_COUNT:     geometry.root_entries = cfg_data_i[15:0];
          REG_VOLUME_SECTORS:       geometry.volume       = cfg_data_i;
          default:                  geometry.root_cluster = cfg_data_i[27:0];
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got.kind         = kind_e'(out_user_i);
        got.first_sector = out_data_i[31:0];
        got.entry_sector = out_data_i[63:32];
        got.entry_offset = out_data_i[75:64];
        got.next_cluster = out_data_i[107:76];
        got.chain_end    = out_data_i[108];
        got.bad_cluster  = out_data_i[109];
        got.range_error  = out_data_i[110];
        got.data_start   = out_data_i[142:111];
        got.root_start   = out_data_i[174:143];
        got.total        = out_data_i[206:175];
        if (expected_results.size() == 0) begin
          failures_o++;
          if (failures_o <= 10) begin
            $display("result beat %0d arrived with nothing expected", results_o);
          end
        end else begin
          want = expected_results.pop_front();
          compare_field("fat_kind", 32'(want.kind), 32'(got.kind));
          compare_field("cluster_first_sector", want.first_sector, got.first_sector);
          compare_field("fat_entry_sector", want.entry_sector, got.entry_sector);
          compare_field("fat_entry_offset", 32'(want.entry_offset), 32'(got.entry_offset));
          compare_field("cluster_out", want.next_cluster, got.next_cluster);
          compare_field("chain_end", 32'(want.chain_end), 32'(got.chain_end));
          compare_field("bad_cluster", 32'(want.bad_cluster), 32'(got.bad_cluster));
          compare_field("range_error", 32'(want.range_error), 32'(got.range_error));
          compare_field("data_start_sector", want.data_start, got.data_start);
          compare_field("root_start_sector", want.root_start, got.root_start);
          compare_field("cluster_total", want.total, got.total);
        end
        results_o++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_lookup(geometry, in_user_i, in_data_i));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

/* tb/fat_cluster_address_and_chain_decode_test.sv */
// Top of the testbench: clock, reset, stimulus, output back-pressure and the verdict.
module fat_cluster_address_and_chain_decode_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fatcd_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold = 200;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [95:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [207:0]        m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int          failures;
  int          pending;
  int          results_checked;
  int          beats_sent;
  int          results_taken;
  int          geometries;
  int          cmd_count[4];
  logic [31:0] data_hint;

  fat_cluster_address_and_chain_decode uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fatcd_lookup_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .failures_o  (failures),
    .pending_o   (pending),
    .results_o   (results_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] overhead_estimate(logic [31:0] res, copies, fat_size, roots);
    return 32'(res[15:0]) + 32'(copies[7:0]) * fat_size + 32'(roots[15:0] >> 4);
  endfunction

  task automatic send_beat(input logic [1:0] cmd, input logic [31:0] cl, sec, word);
    int unsigned gap;
    gap = (((beats_sent / 48) % 3) != 1) ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = cmd;
    s_axis_tdata  = {word, sec, cl};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    beats_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = value;
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [31:0] sbl, csl, res, copies, fat_size, roots,
                              volume, root_cluster);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    write_reg(REG_SECTOR_BYTES_LOG2, sbl);
    write_reg(REG_CLUSTER_SECTORS_LOG2, csl);
    write_reg(REG_RESERVED_SECTORS, res);
    write_reg(REG_FAT_COPIES, copies);
    write_reg(REG_FAT_SIZE_SECTORS, fat_size);
    write_reg(REG_ROOT_ENTRY_COUNT, roots);
    write_reg(REG_VOLUME_SECTORS, volume);
    write_reg(REG_ROOT_START_CLUSTER, root_cluster);
    cfg_we    = 1'b0;
    data_hint = overhead_estimate(res, copies, fat_size, roots);
    geometries++;
  endtask

  task automatic set_random_geometry();
    logic [31:0] res, copies, fat_size, roots, span;
    res      = ($urandom & 32'hffff_0000) | $urandom_range(0, 40);
    copies   = ($urandom & 32'hffff_ff00) | $urandom_range(0, 3);
    fat_size = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 2000);
    roots    = ($urandom & 32'hffff_0000) | ($urandom_range(0, 1) ? 0 : $urandom_range(0, 1024));
    case ($urandom_range(0, 3))
      0: span = $urandom_range(0, 9000);
      1: span = $urandom_range(0, 6000000);
      2: span = $urandom;
      default: span = $urandom_range(0, 200);
    endcase
    set_geometry($urandom, $urandom, res, copies, fat_size, roots,
                 overhead_estimate(res, copies, fat_size, roots) + span, $urandom);
  endtask

  task automatic send_random_items(input int count);
    logic [1:0]  cmd;
    logic [31:0] cl, sec, word;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 15);
      cmd = (pick < 5) ? CMD_LOCATE : (pick < 10) ? CMD_SECTOR :
            (pick < 15) ? CMD_DECODE : CmdUnused;
      case ($urandom_range(0, 3))
        0: cl = $urandom_range(0, 3);
        1: cl = $urandom_range(2, 70000);
        2: cl = $urandom;
        default: cl = 32'hffff_ffff - $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 3))
        0: sec = data_hint + $urandom_range(0, 80) - 32'd40;
        1: sec = $urandom;
        2: sec = $urandom_range(0, 64);
        default: sec = 32'hffff_ffff - $urandom_range(0, 3);
      endcase
      word = $urandom;
      case ($urandom_range(0, 4))
        0: word[11:0] = 12'hff0 + 12'($urandom_range(6, 15));
        1: word[15:4] = 12'hff0 + 12'($urandom_range(6, 15));
        2: word[15:0] = 16'hfff0 + 16'($urandom_range(6, 15));
        3: word[27:0] = 28'hffffff0 + 28'($urandom_range(6, 15));
        default: word = 32'hffff_fff0 + $urandom_range(6, 15);
      endcase
      send_beat(cmd, cl, sec, word);
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_SECTOR_BYTES_LOG2;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_LOCATE;
    beats_sent    = 0;
    geometries    = 1;
    data_hint     = 32'd35;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Geometry after reset: empty volume, so exFAT with no clusters.
    send_beat(CMD_LOCATE, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_LOCATE, 32'd1, 32'd0, 32'd0);
    send_beat(CMD_LOCATE, 32'd2, 32'd0, 32'd0);
    send_beat(CMD_LOCATE, 32'd3, 32'd0, 32'd0);
    send_beat(CMD_LOCATE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_SECTOR, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_SECTOR, 32'd0, 32'd34, 32'd0);
    send_beat(CMD_SECTOR, 32'd0, 32'd35, 32'd0);
    send_beat(CMD_SECTOR, 32'd0, 32'd36, 32'd0);
    send_beat(CMD_SECTOR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CMD_DECODE, 32'd0, 32'd0, 32'd0);
    send_beat(CMD_DECODE, 32'd1, 32'd0, 32'hffff_fff8);
    send_beat(CMD_DECODE, 32'd2, 32'd0, 32'hffff_fff7);
    send_beat(CMD_DECODE, 32'd2, 32'd0, 32'hffff_fff6);
    send_beat(CMD_DECODE, 32'd3, 32'd0, 32'hffff_ffff);
    send_beat(CMD_DECODE, 32'd3, 32'd0, 32'h0fff_fff8);
    send_beat(CMD_DECODE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CmdUnused, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(CmdUnused, 32'd0, 32'd0, 32'd0);
    send_random_items(40);

    set_geometry(32'd9, 32'd0, 32'd1, 32'd2, 32'd9, 32'd224, 32'd2880, 32'd2);
    send_random_items(75);
    set_geometry(32'd9, 32'd2, 32'd4, 32'd2, 32'd200, 32'd512, 32'd200000, 32'd2);
    send_random_items(75);
    set_geometry(32'd9, 32'd3, 32'd32, 32'd2, 32'd1000, 32'd0, 32'd2000000, 32'd2);
    send_random_items(75);
    set_geometry(32'd15, 32'd7, 32'd65535, 32'd255, 32'hffff_ffff, 32'd65535,
                 32'hffff_ffff, 32'h0fff_ffff);
    send_random_items(60);
    set_geometry(32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'hffff_ffff, 32'd2);
    send_random_items(60);
    set_geometry(32'd12, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd4086, 32'd5);
    send_random_items(20);
    set_geometry(32'd13, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd4087, 32'd5);
    send_random_items(20);
    set_geometry(32'd9, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd65526, 32'd7);
    send_random_items(20);
    set_geometry(32'd9, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd65527, 32'd7);
    send_random_items(20);
    set_geometry(32'd9, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd3, 32'h0fff_ffff);
    send_random_items(20);
    repeat (8) begin
      set_random_geometry();
      send_random_items(55);
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    $display("Run covered %0d lookups over %0d volume geometries: %0d locate, %0d sector,",
             beats_sent, geometries, cmd_count[CMD_LOCATE], cmd_count[CMD_SECTOR]);
    $display("%0d decode and %0d unused-command beats; %0d results compared, %0d mismatches.",
             cmd_count[CMD_DECODE], cmd_count[CmdUnused], results_checked, failures);
    if (failures == 0) begin
      $display("fat_cluster_address_and_chain_decode verification clean");
    end else begin
      $display("fat_cluster_address_and_chain_decode verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    m_axis_tready = 1'b0;
    results_taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_taken == 300 || results_taken == 650) begin
        hold = LongHold;
      end else begin
        hold = (((results_taken / 40) % 3) != 1) ? $urandom_range(0, 7) : 0;
      end
      if (hold != 0) begin
        m_axis_tready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_taken++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we ||
          !rst_ni) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timed out after %0d cycles without a beat.", quiet);
    $display("fat_cluster_address_and_chain_decode verification failed");
    $finish;
  end

endmodule
